### hw/rtl/assert_macros.svh
// assertion helpers, clocked with a disable on the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// full property given by the caller
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IF(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_CLKD(label, clk, rst_n, prop)
`define ASSERT_IF(label, clk, rst_n, pre, post)

`endif

`endif

### hw/rtl/mes_pkg.sv
package mes_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 60;
  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int STEP_W      = 62;
  localparam int ITER_W      = 16;
  localparam int PROD_W      = COORD_BITS + STEP_W;

  localparam int IN_FIELD_W  = 12;
  localparam int IN_TDATA_W  = 24;
  localparam int SHADE_W     = 8;
  localparam int GROUP_W     = 2;
  localparam int GLYPH_W     = 7;
  localparam int OUT_TDATA_W = 40;

  localparam int RAMP_LEN    = 70;
  localparam int NUM_GROUPS  = 3;
  localparam int SHADE_STEPS = RAMP_LEN * NUM_GROUPS;
  localparam int GLYPH_IDX_W = $clog2(RAMP_LEN);
  localparam int SCALED_W    = 24;
  localparam int DIV_STEPS   = SCALED_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] SIGN_BIT  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] POS_MAX   = ~SIGN_BIT;
  localparam logic [WORD_W-1:0] FIX_TWO   = WORD_W'(2) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FIX_FOUR  = WORD_W'(4) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRAC_BITS;
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_RE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_IM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 2'd3;

  // which product travels through the multiplier pipeline
  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI
  } mul_op_e;

  typedef struct packed {
    logic    load_item;
    logic    coord_mul;
    logic    coord_add;
    logic    take_mag;
    logic    mul_issue;
    mul_op_e mul_op;
    logic    test;
    logic    update;
    logic    scale;
    logic    shade_zero;
    logic    div_start;
    logic    out_load;
  } mes_cmd_t;

  typedef struct packed {
    logic big;
    logic escaped;
    logic at_limit;
    logic maxit_zero;
    logic cross_done;
    logic div_done;
  } mes_status_t;

  // 70-entry ascii ramp, dense to sparse
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [GLYPH_IDX_W-1:0] idx);
    logic [GLYPH_W-1:0] g;
    case (idx)
      7'd0:  g = 7'h24;  7'd1:  g = 7'h40;  7'd2:  g = 7'h42;  7'd3:  g = 7'h25;
      7'd4:  g = 7'h38;  7'd5:  g = 7'h26;  7'd6:  g = 7'h57;  7'd7:  g = 7'h4D;
      7'd8:  g = 7'h23;  7'd9:  g = 7'h2C;  7'd10: g = 7'h2A;  7'd11: g = 7'h6F;
      7'd12: g = 7'h61;  7'd13: g = 7'h68;  7'd14: g = 7'h6B;  7'd15: g = 7'h62;
      7'd16: g = 7'h64;  7'd17: g = 7'h70;  7'd18: g = 7'h71;  7'd19: g = 7'h77;
      7'd20: g = 7'h6D;  7'd21: g = 7'h5A;  7'd22: g = 7'h4F;  7'd23: g = 7'h30;
      7'd24: g = 7'h51;  7'd25: g = 7'h4C;  7'd26: g = 7'h43;  7'd27: g = 7'h4A;
      7'd28: g = 7'h55;  7'd29: g = 7'h59;  7'd30: g = 7'h58;  7'd31: g = 7'h7A;
      7'd32: g = 7'h63;  7'd33: g = 7'h76;  7'd34: g = 7'h75;  7'd35: g = 7'h6E;
      7'd36: g = 7'h78;  7'd37: g = 7'h72;  7'd38: g = 7'h6A;  7'd39: g = 7'h66;
      7'd40: g = 7'h74;  7'd41: g = 7'h2F;  7'd42: g = 7'h5C;  7'd43: g = 7'h7C;
      7'd44: g = 7'h28;  7'd45: g = 7'h29;  7'd46: g = 7'h31;  7'd47: g = 7'h7B;
      7'd48: g = 7'h7D;  7'd49: g = 7'h5B;  7'd50: g = 7'h5D;  7'd51: g = 7'h3F;
      7'd52: g = 7'h2D;  7'd53: g = 7'h5F;  7'd54: g = 7'h2B;  7'd55: g = 7'h7E;
      7'd56: g = 7'h3C;  7'd57: g = 7'h3E;  7'd58: g = 7'h69;  7'd59: g = 7'h21;
      7'd60: g = 7'h6C;  7'd61: g = 7'h49;  7'd62: g = 7'h3B;  7'd63: g = 7'h3A;
      7'd64: g = 7'h22;  7'd65: g = 7'h5E;  7'd66: g = 7'h60;  7'd67: g = 7'h27;
      7'd68: g = 7'h2E;  7'd69: g = 7'h20;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/mes_fixmul.sv
module mes_fixmul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  mes_pkg::mul_op_e             in_op_i,
  input  logic                         in_neg_i,
  input  logic [mes_pkg::WORD_W-1:0]   a_i,
  input  logic [mes_pkg::WORD_W-1:0]   b_i,
  output logic                         out_valid_o,
  output mes_pkg::mul_op_e             out_op_o,
  output logic [mes_pkg::WORD_W-1:0]   res_o
);

  localparam int W = mes_pkg::WORD_W;
  localparam int H = mes_pkg::HALF_W;

  logic [3:0] valid_q;
  mes_pkg::mul_op_e op1_q, op2_q, op3_q, op4_q;
  logic neg1_q, neg2_q, neg3_q;

  logic [W-1:0]   ll_d, lh_d, hl_d, hh_d;
  logic [W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [2*W-1:0] hhll_q;
  logic [W:0]     mid_q;
  logic [2*W-1:0] mid_ext, sum;
  logic [W-1:0]   m_q, res_q;

  // 32x32 partial products of the two magnitudes
  assign ll_d = a_i[H-1:0] * b_i[H-1:0];
  assign lh_d = a_i[H-1:0] * b_i[W-1:H];
  assign hl_d = a_i[W-1:H] * b_i[H-1:0];
  assign hh_d = a_i[W-1:H] * b_i[W-1:H];

  assign mid_ext = {{(W-1-H){1'b0}}, mid_q, {H{1'b0}}};
  assign sum     = hhll_q + mid_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    ll_q   <= ll_d;
    lh_q   <= lh_d;
    hl_q   <= hl_d;
    hh_q   <= hh_d;
    op1_q  <= in_op_i;
    neg1_q <= in_neg_i;
    // stage 2
    hhll_q <= {hh_q, ll_q};
    mid_q  <= {1'b0, lh_q} + {1'b0, hl_q};
    op2_q  <= op1_q;
    neg2_q <= neg1_q;
    // stage 3: drop the fraction bits, truncating the magnitude
    m_q    <= sum[mes_pkg::FRAC_BITS +: W];
    op3_q  <= op2_q;
    neg3_q <= neg2_q;
    // stage 4: apply the sign
    res_q  <= neg3_q ? (W'(0) - m_q) : m_q;
    op4_q  <= op3_q;
  end

  assign out_valid_o = valid_q[3];
  assign out_op_o    = op4_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/mes_div.sv
module mes_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mes_pkg::SCALED_W-1:0]   dividend_i,
  input  logic [mes_pkg::ITER_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [mes_pkg::SCALED_W-1:0]   quotient_o
);

  localparam int QW = mes_pkg::SCALED_W;
  localparam int RW = mes_pkg::ITER_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [mes_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [QW-1:0]                 quo_q;
  logic [RW-1:0]                 rem_q, dvs_q;
  logic [RW:0]                   shifted, trial;
  logic                          fits, last;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_q, quo_q[QW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign last    = cnt_q == mes_pkg::DIV_CNT_W'(mes_pkg::DIV_STEPS - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QW-2:0], fits};
      rem_q <= fits ? trial[RW-1:0] : shifted[RW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/mes_dp.sv
module mes_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mes_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [mes_pkg::WORD_W-1:0]       cfg_wdata_i,
  input  logic [mes_pkg::IN_FIELD_W-1:0]   column_i,
  input  logic [mes_pkg::IN_FIELD_W-1:0]   row_index_i,
  input  mes_pkg::mes_cmd_t                cmd_i,
  output mes_pkg::mes_status_t             status_o,
  output logic [mes_pkg::ITER_W-1:0]       iteration_count_o,
  output logic [mes_pkg::SHADE_W-1:0]      shade_index_o,
  output logic [mes_pkg::GROUP_W-1:0]      color_group_o,
  output logic [mes_pkg::GLYPH_W-1:0]      glyph_char_o
);

  localparam int W = mes_pkg::WORD_W;

  // configuration
  logic [W-1:0]                origin_re_q, origin_im_q;
  logic [mes_pkg::STEP_W-1:0]  step_q;
  logic [mes_pkg::ITER_W-1:0]  max_iter_q;

  // per-item state
  logic [mes_pkg::COORD_BITS-1:0] col_q, row_q;
  logic [mes_pkg::PROD_W-1:0]     prod_re_q, prod_im_q;
  logic [W-1:0] c_re_q, c_im_q, re_q, im_q;
  logic [W-1:0] mag_re_q, mag_im_q;
  logic         sgn_re_q, sgn_im_q;
  logic [W-1:0] sr_q, si_q, cross_q, diff_q, dbl_q;
  logic [mes_pkg::ITER_W-1:0]   count_q, count_inc;
  logic [mes_pkg::SCALED_W-1:0] scaled_q;
  logic [mes_pkg::SHADE_W-1:0]  shade_q, glyph_idx;
  logic [mes_pkg::GROUP_W-1:0]  group;

  // product pipeline and divider
  logic [W-1:0]             mul_a, mul_b, mul_res;
  logic                     mul_neg, mul_valid;
  mes_pkg::mul_op_e         mul_op_out;
  logic                     div_done;
  logic [mes_pkg::SCALED_W-1:0] quotient;
  logic                     escaped;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] s;
    s = a + b;
    if ((a[W-1] == b[W-1]) && (s[W-1] != a[W-1])) begin
      return a[W-1] ? mes_pkg::SIGN_BIT : mes_pkg::POS_MAX;
    end
    return s;
  endfunction

  // origin plus position times step, clipped at the top of the signed range
  function automatic logic [W-1:0] coord_sum(input logic [W-1:0] origin,
                                             input logic [mes_pkg::PROD_W-1:0] prod);
    logic [W:0] sum;
    logic       hi_nz;
    hi_nz = |prod[mes_pkg::PROD_W-1:W];
    sum   = {1'b0, origin ^ mes_pkg::SIGN_BIT} + {1'b0, prod[W-1:0]};
    if (hi_nz || sum[W]) begin
      return mes_pkg::POS_MAX;
    end
    return sum[W-1:0] ^ mes_pkg::SIGN_BIT;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q <= '0;
      origin_im_q <= '0;
      step_q      <= mes_pkg::STEP_ONE;
      max_iter_q  <= mes_pkg::ITER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mes_pkg::REG_ORIGIN_RE: origin_re_q <= cfg_wdata_i;
        mes_pkg::REG_ORIGIN_IM: origin_im_q <= cfg_wdata_i;
        mes_pkg::REG_STEP:      step_q      <= cfg_wdata_i[mes_pkg::STEP_W-1:0];
        mes_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[mes_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_inc = count_q + mes_pkg::ITER_W'(1);
  assign escaped   = (sr_q + si_q) >= mes_pkg::FIX_FOUR;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      col_q <= column_i[mes_pkg::COORD_BITS-1:0];
      row_q <= row_index_i[mes_pkg::COORD_BITS-1:0];
    end
    if (cmd_i.coord_mul) begin
      prod_re_q <= col_q * step_q;
      prod_im_q <= row_q * step_q;
    end
    if (cmd_i.coord_add) begin
      c_re_q  <= coord_sum(origin_re_q, prod_re_q);
      c_im_q  <= coord_sum(origin_im_q, prod_im_q);
      re_q    <= '0;
      im_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.update) begin
      re_q <= sat_add(diff_q, c_re_q);
      im_q <= sat_add(dbl_q, c_im_q);
    end else if (cmd_i.test && !escaped) begin
      count_q <= count_inc;
    end
    if (cmd_i.take_mag) begin
      mag_re_q <= re_q[W-1] ? (W'(0) - re_q) : re_q;
      mag_im_q <= im_q[W-1] ? (W'(0) - im_q) : im_q;
      sgn_re_q <= re_q[W-1];
      sgn_im_q <= im_q[W-1];
    end
    if (mul_valid) begin
      case (mul_op_out)
        mes_pkg::OP_RR: sr_q    <= mul_res;
        mes_pkg::OP_II: si_q    <= mul_res;
        mes_pkg::OP_RI: cross_q <= mul_res;
        default: ;
      endcase
    end
    if (cmd_i.test) begin
      diff_q <= sr_q - si_q;
      dbl_q  <= {cross_q[W-2:0], 1'b0};
    end
    if (cmd_i.scale) begin
      scaled_q <= mes_pkg::SCALED_W'(max_iter_q - count_q) *
                  mes_pkg::SCALED_W'(mes_pkg::SHADE_STEPS);
    end
    if (cmd_i.shade_zero) begin
      shade_q <= '0;
    end else if (div_done) begin
      shade_q <= quotient[mes_pkg::SHADE_W-1:0];
    end
  end

  always_comb begin
    case (cmd_i.mul_op)
      mes_pkg::OP_RR: begin
        mul_a   = mag_re_q;
        mul_b   = mag_re_q;
        mul_neg = 1'b0;
      end
      mes_pkg::OP_II: begin
        mul_a   = mag_im_q;
        mul_b   = mag_im_q;
        mul_neg = 1'b0;
      end
      default: begin
        mul_a   = mag_re_q;
        mul_b   = mag_im_q;
        mul_neg = sgn_re_q ^ sgn_im_q;
      end
    endcase
  end

  mes_fixmul u_fixmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.mul_issue),
    .in_op_i     (cmd_i.mul_op),
    .in_neg_i    (mul_neg),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .out_valid_o (mul_valid),
    .out_op_o    (mul_op_out),
    .res_o       (mul_res)
  );

  mes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (scaled_q),
    .divisor_i  (max_iter_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // colour group and ramp position
  always_comb begin
    if (shade_q >= mes_pkg::SHADE_W'(2 * mes_pkg::RAMP_LEN)) begin
      group     = mes_pkg::GROUP_W'(2);
      glyph_idx = shade_q - mes_pkg::SHADE_W'(2 * mes_pkg::RAMP_LEN);
    end else if (shade_q >= mes_pkg::SHADE_W'(mes_pkg::RAMP_LEN)) begin
      group     = mes_pkg::GROUP_W'(1);
      glyph_idx = shade_q - mes_pkg::SHADE_W'(mes_pkg::RAMP_LEN);
    end else begin
      group     = '0;
      glyph_idx = shade_q;
    end
  end

  assign status_o.big        = (mag_re_q >= mes_pkg::FIX_TWO) || (mag_im_q >= mes_pkg::FIX_TWO);
  assign status_o.escaped    = escaped;
  assign status_o.at_limit   = count_inc >= max_iter_q;
  assign status_o.maxit_zero = max_iter_q == '0;
  assign status_o.cross_done = mul_valid && (mul_op_out == mes_pkg::OP_RI);
  assign status_o.div_done   = div_done;

  assign iteration_count_o = count_q;
  assign shade_index_o     = shade_q;
  assign color_group_o     = group;
  assign glyph_char_o      = mes_pkg::glyph_of(glyph_idx[mes_pkg::GLYPH_IDX_W-1:0]);

endmodule

### hw/rtl/mes_ctrl.sv
module mes_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_free_i,
  input  mes_pkg::mes_status_t  status_i,
  output mes_pkg::mes_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COORD_MUL,
    ST_COORD_ADD,
    ST_MAG,
    ST_CHECK,
    ST_ISSUE_II,
    ST_ISSUE_RI,
    ST_WAIT_MUL,
    ST_TEST,
    ST_UPDATE,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_COORD_MUL;
        end
      end
      ST_COORD_MUL: begin
        cmd_o.coord_mul = 1'b1;
        state_d         = ST_COORD_ADD;
      end
      ST_COORD_ADD: begin
        cmd_o.coord_add = 1'b1;
        state_d         = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.take_mag = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.big) begin
          state_d = ST_SCALE;
        end else begin
          cmd_o.mul_issue = 1'b1;
          cmd_o.mul_op    = mes_pkg::OP_RR;
          state_d         = ST_ISSUE_II;
        end
      end
      ST_ISSUE_II: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_op    = mes_pkg::OP_II;
        state_d         = ST_ISSUE_RI;
      end
      ST_ISSUE_RI: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_op    = mes_pkg::OP_RI;
        state_d         = ST_WAIT_MUL;
      end
      ST_WAIT_MUL: begin
        // cross product is the last one out
        if (status_i.cross_done) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd_o.test = 1'b1;
        if (status_i.escaped || status_i.at_limit) begin
          state_d = ST_SCALE;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MAG;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        if (status_i.maxit_zero) begin
          cmd_o.shade_zero = 1'b1;
          state_d          = ST_OUT;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

### hw/rtl/mandelbrot_escape_shader_top.sv
// escape-time shader: one pixel (column, row_index) in, one shaded result out
// each iteration passes its three products (re*re, im*im, re*im) in turn through the
// four-stage shared product pipeline; the shade comes from a restoring divider
// one pixel in flight at a time; the next item is taken while a result waits
// reset: async active low; origin 0, step 1.0, limit 1000, output register empty
`include "assert_macros.svh"

module mandelbrot_escape_shader_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mes_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // column, row_index
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // iteration_count, shade_index, color_group, glyph_char, zero pad
  output logic [mes_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [mes_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [mes_pkg::WORD_W-1:0]         cfg_wdata_i
);

  localparam int FW = mes_pkg::IN_FIELD_W;
  localparam int PAD_W = mes_pkg::OUT_TDATA_W - mes_pkg::ITER_W - mes_pkg::SHADE_W -
                         mes_pkg::GROUP_W - mes_pkg::GLYPH_W;

  mes_pkg::mes_cmd_t    cmd;
  mes_pkg::mes_status_t status;

  logic [mes_pkg::ITER_W-1:0]  count;
  logic [mes_pkg::SHADE_W-1:0] shade;
  logic [mes_pkg::GROUP_W-1:0] group;
  logic [mes_pkg::GLYPH_W-1:0] glyph;

  logic                            out_valid_q;
  logic [mes_pkg::ITER_W-1:0]      out_count_q;
  logic [mes_pkg::SHADE_W-1:0]     out_shade_q;
  logic [mes_pkg::GROUP_W-1:0]     out_group_q;
  logic [mes_pkg::GLYPH_W-1:0]     out_glyph_q;
  logic                            out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  mes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mes_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .column_i          (s_axis_tdata[FW-1:0]),
    .row_index_i       (s_axis_tdata[2*FW-1:FW]),
    .cmd_i             (cmd),
    .status_o          (status),
    .iteration_count_o (count),
    .shade_index_o     (shade),
    .color_group_o     (group),
    .glyph_char_o      (glyph)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_count_q <= count;
      out_shade_q <= shade;
      out_group_q <= group;
      out_glyph_q <= glyph;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_glyph_q, out_group_q, out_shade_q, out_count_q};

  // a result never overwrites one still waiting
  `ASSERT_IF(a_load_into_free, clk_i, rst_ni, cmd.out_load, out_free)
  // one pixel in flight: no second accept right after the first
  `ASSERT_CLKD(a_single_item, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_IF(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid, out_count_q != '0)
  `ASSERT_IF(a_shade_range, clk_i, rst_ni, m_axis_tvalid,
             (out_shade_q < 8'd210) && (out_group_q != 2'd3))

endmodule

### bench/mes_result_checker.sv
`timescale 1ns / 1ps

module mes_result_checker
  import mes_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // column, row_index
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // iteration_count, shade_index, color_group, glyph_char, zero pad
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [WORD_W-1:0]      cfg_wdata_i,
  output int                     mismatches_o,
  output int                     in_flight_o
);

  localparam int PROD_FULL_W = 2 * WORD_W;
  localparam int SHADE_LSB   = ITER_W;
  localparam int GROUP_LSB   = SHADE_LSB + SHADE_W;
  localparam int GLYPH_LSB   = GROUP_LSB + GROUP_W;

  // glyph ramp, dense to sparse, first character in the top byte
  localparam logic [8*RAMP_LEN-1:0] GLYPH_RAMP =
    "$@B%8&WM#,*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:\"^`'. ";

  typedef struct {
    logic [ITER_W-1:0]  count;
    logic [SHADE_W-1:0] shade;
    logic [GROUP_W-1:0] group;
    logic [GLYPH_W-1:0] glyph;
  } pixel_shade_t;

  pixel_shade_t expected_shades[$];

  logic [WORD_W-1:0] view_re;
  logic [WORD_W-1:0] view_im;
  logic [STEP_W-1:0] view_step;
  logic [ITER_W-1:0] iter_limit;

  function automatic logic [WORD_W-1:0] fx_mag(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? -x : x;
  endfunction

  // magnitude product truncated toward zero, sign applied afterwards
  function automatic logic [WORD_W-1:0] fx_mul(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [PROD_FULL_W-1:0] prod;
    logic [WORD_W-1:0]      m;
    prod = PROD_FULL_W'(fx_mag(a)) * PROD_FULL_W'(fx_mag(b));
    m = WORD_W'(prod >> FRAC_BITS);
    return (a[WORD_W-1] ^ b[WORD_W-1]) ? -m : m;
  endfunction

  function automatic logic [WORD_W-1:0] sat_sum(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] s;
    s = a + b;
    if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1])
      return a[WORD_W-1] ? SIGN_BIT : POS_MAX;
    return s;
  endfunction

  // origin plus position times step, clipped at the top of the signed range
  function automatic logic [WORD_W-1:0] point_coord(input logic [WORD_W-1:0] origin,
                                                    input logic [IN_FIELD_W-1:0] pos);
    logic [PROD_FULL_W-1:0] prod;
    logic [WORD_W:0]        sum;
    prod = PROD_FULL_W'(pos[COORD_BITS-1:0]) * PROD_FULL_W'(view_step);
    if (prod[PROD_FULL_W-1:WORD_W] != '0) return POS_MAX;
    sum = {1'b0, origin ^ SIGN_BIT} + {1'b0, prod[WORD_W-1:0]};
    if (sum[WORD_W]) return POS_MAX;
    return sum[WORD_W-1:0] ^ SIGN_BIT;
  endfunction

  function automatic pixel_shade_t shade_pixel(input logic [IN_FIELD_W-1:0] col,
                                               input logic [IN_FIELD_W-1:0] row);
    logic [WORD_W-1:0] c_re, c_im, re, im, sq_re, sq_im, cross_prod, mag_sq;
    int unsigned       count, shade, limit;
    logic              done;
    pixel_shade_t      r;
    c_re  = point_coord(view_re, col);
    c_im  = point_coord(view_im, row);
    re    = '0;
    im    = '0;
    count = 0;
    limit = iter_limit;
    done  = 1'b0;
    while (!done) begin
      if (fx_mag(re) >= FIX_TWO || fx_mag(im) >= FIX_TWO) begin
        done = 1'b1;
      end else begin
        sq_re  = fx_mul(re, re);
        sq_im  = fx_mul(im, im);
        mag_sq = sq_re + sq_im;
        if (mag_sq >= FIX_FOUR) begin
          done = 1'b1;
        end else begin
          count++;
          if (count >= limit) begin
            done = 1'b1;
          end else begin
            cross_prod = fx_mul(re, im);
            re         = sat_sum(sq_re - sq_im, c_re);
            im         = sat_sum(cross_prod << 1, c_im);
          end
        end
      end
    end
    // a zero limit gives the darkest shade without dividing
    shade = 0;
    if (limit != 0 && count <= limit)
      shade = ((limit - count) * SHADE_STEPS) / limit;
    r.count = ITER_W'(count);
    r.shade = SHADE_W'(shade);
    r.group = GROUP_W'(shade / RAMP_LEN);
    r.glyph = GLYPH_RAMP[8 * (RAMP_LEN - 1 - int'(shade % RAMP_LEN)) +: GLYPH_W];
    return r;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_shade_t want;
    if (!rst_ni) begin
      view_re      = '0;
      view_im      = '0;
      view_step    = STEP_ONE;
      iter_limit   = ITER_RESET;
      mismatches_o = 0;
      expected_shades.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ORIGIN_RE: view_re    = cfg_wdata_i;
          REG_ORIGIN_IM: view_im    = cfg_wdata_i;
          REG_STEP:      view_step  = cfg_wdata_i[STEP_W-1:0];
          REG_MAX_ITER:  iter_limit = cfg_wdata_i[ITER_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        expected_shades.push_back(shade_pixel(s_tdata_i[0 +: IN_FIELD_W],
                                              s_tdata_i[IN_FIELD_W +: IN_FIELD_W]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_shades.size() == 0) begin
          $display("%0t: result with nothing expected, expected none got %h",
                   $time, m_tdata_i);
          mismatches_o++;
        end else begin
          want = expected_shades.pop_front();
          report_field("iteration_count", want.count, m_tdata_i[0 +: ITER_W]);
          report_field("shade_index", want.shade, m_tdata_i[SHADE_LSB +: SHADE_W]);
          report_field("color_group", want.group, m_tdata_i[GROUP_LSB +: GROUP_W]);
          report_field("glyph_char", want.glyph, m_tdata_i[GLYPH_LSB +: GLYPH_W]);
        end
      end
    end
    in_flight_o = expected_shades.size();
  end

endmodule

### bench/tb_mandelbrot_escape_shader_top.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_shader_top;
  import mes_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 10;
  localparam int QUIET_LIMIT  = 100000;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 200;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 50;

  localparam logic [WORD_W-1:0] FIX_ONE  = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] STEP_TOP = WORD_W'({STEP_W{1'b1}});

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // column, row_index
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // iteration_count, shade_index, color_group, glyph_char, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [WORD_W-1:0]      cfg_wdata_i;

  int   mismatches;
  int   in_flight;
  int   quiet_cycles = 0;
  logic pixel_taken  = 1'b0;
  logic tx_gaps      = 1'b1;
  logic rx_stalls    = 1'b1;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mandelbrot_escape_shader_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mes_result_checker shade_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .in_flight_o  (in_flight)
  );

  always @(posedge clk_i) begin
    pixel_taken <= s_axis_tvalid && s_axis_tready;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, 60);
  endfunction

  initial begin : receiver
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_pixel(input logic [IN_FIELD_W-1:0] col,
                            input logic [IN_FIELD_W-1:0] row);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {row, col};
    do @(negedge clk_i); while (!pixel_taken);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_view(input logic [WORD_W-1:0] re, input logic [WORD_W-1:0] im,
                          input logic [WORD_W-1:0] step, input int unsigned limit);
    drain_results();
    write_reg(REG_ORIGIN_RE, re);
    write_reg(REG_ORIGIN_IM, im);
    write_reg(REG_STEP, step);
    write_reg(REG_MAX_ITER, WORD_W'(limit));
  endtask

  initial begin : stimulus
    int unsigned zoom;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset view: unit step, so pixels land on whole numbers; corners saturate
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(2, 0);

    // limit of zero takes the darkest shade without a division; then limits of one and two
    set_view(0, 0, FIX_ONE, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    set_view(0, 0, FIX_ONE, 1);
    send_pixel(0, 0);
    set_view(0, 0, FIX_ONE, 2);
    send_pixel(0, 0);
    send_pixel(1, 1);

    // extreme origins and the widest step, with the highest limit
    set_view(SIGN_BIT, POS_MAX, STEP_TOP, 65535);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);

    // classic view of the whole set
    set_view(-(WORD_W'(2) << FRAC_BITS), -(WORD_W'(3) << (FRAC_BITS - 1)),
             WORD_W'(3) << (FRAC_BITS - 6), 64);
    send_pixel(0, 0);
    send_pixel(32, 32);
    send_pixel(43, 32);
    send_pixel(16, 32);
    send_pixel(63, 63);
    send_pixel(20, 10);

    // zero step pins every pixel on the cusp
    set_view(WORD_W'(1) << (FRAC_BITS - 2), 0, 0, 200);
    send_pixel(4095, 4095);

    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(0, 9) < 8) begin
        zoom = $urandom_range(8, 18);
        set_view(-(WORD_W'(5) << (FRAC_BITS - 1)) + ({$urandom, $urandom} >> 3),
                 -(WORD_W'(3) << (FRAC_BITS - 1)) + ({$urandom, $urandom} >> 4),
                 {32'd0, $urandom} << zoom,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(61, 300)
                                              : $urandom_range(2, 60));
      end else begin
        // anywhere in the number range, mostly saturating or escaping at once
        set_view({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom} >> 2, $urandom_range(2, 2000));
      end
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        send_pixel(IN_FIELD_W'($urandom_range(0, 4095)),
                   IN_FIELD_W'($urandom_range(0, 4095)));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mes_pkg.sv
hw/rtl/mes_fixmul.sv
hw/rtl/mes_div.sv
hw/rtl/mes_dp.sv
hw/rtl/mes_ctrl.sv
hw/rtl/mandelbrot_escape_shader_top.sv
bench/mes_result_checker.sv
bench/tb_mandelbrot_escape_shader_top.sv
